@@ hdl/nsr_pkg.sv @@
`timescale 1ns / 1ps
package nsr_pkg;
  localparam int MaxNodesDefault = 16;
  localparam int IdW = 32;
  localparam int SlotW = 16;
  localparam int TimeW = 48;
  localparam int LimW = 40;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0, CMD_REMOVE = 2'd1, CMD_KEEPALIVE = 2'd2, CMD_CHECK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOT_FOUND = 2'd2, ST_NONE = 2'd3
  } status_t;

  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_SILENCE = 2'd1;
  localparam logic [1:0] REG_PAD = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [IdW-1:0]   node_id;
    logic [TimeW-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdW-1:0]   result_id;
    logic [SlotW-1:0] result_slot;
    logic [4:0]       node_count;
    logic             last_result;
  } out_item_t;

  // token passed down the row of cells on each shift
  typedef struct packed {
    logic             valid;
    logic             occ;
    logic [IdW-1:0]   id;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] last_seen;
    logic [TimeW-1:0] deadline;
  } rec_t;
endpackage

@@ hdl/nsr_cell.sv @@
`timescale 1ns / 1ps
// One table entry. Rotates its record into the next cell when shift is high;
// the top level closes the ring, so a full rotation visits every entry at
// the ring head once.
module nsr_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  nsr_pkg::rec_t  rec_in,
  output nsr_pkg::rec_t  rec_out
);
  import nsr_pkg::*;
  rec_t r;
  always_ff @(posedge clk) begin
    if (rst) begin
      r.valid <= 1'b0;
    end else if (shift) begin
      r.valid <= rec_in.valid;
    end
    if (shift) begin
      r.occ       <= rec_in.occ;
      r.id        <= rec_in.id;
      r.slot      <= rec_in.slot;
      r.last_seen <= rec_in.last_seen;
      r.deadline  <= rec_in.deadline;
    end
  end
  assign rec_out = r;
endmodule

@@ hdl/node_slot_registry_unit.sv @@
`timescale 1ns / 1ps
// Channel    Direction  Transfer
// cmd        in         start & !busy
// cfg        in         cfg_valid & cfg_ready (cfg_ready held high)
// result     out        done, one cycle, no back pressure
// Entries live in a ring of MAX_NODES cells; one pass rotates it once. Create: id scan
// pass, slot sort pass, gap walk (one step per occupied slot), bit-serial remainder
// (skipped if empty), placement pass; a duplicate id ends after the scan. Remove and
// keepalive: one pass; check: one pass, then the marker. Each expired id waits in a
// register for the next expiry or the pass end. Full table: never busy. Final result and
// busy falling share a cycle. Reset empties the table at once; no stall on results.
module node_slot_registry_unit #(
  parameter int MAX_NODES = nsr_pkg::MaxNodesDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  nsr_pkg::in_item_t cmd,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [39:0]       cfg_data,
  output logic              done,
  output nsr_pkg::out_item_t result
);
  import nsr_pkg::*;
  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int RW = $clog2(MAX_NODES + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_IDSCAN, S_SORT, S_GAP, S_MOD, S_ROT, S_NONE
  } state_t;

  state_t state;
  logic [SlotW-1:0] period;
  logic [LimW-1:0] silence_lim, pad;
  in_item_t item;
  logic [IdW-1:0] next_id;
  logic [CW-1:0] live;
  logic [RW-1:0] cnt;
  logic found, placed, any;
  logic [SlotW-1:0] new_slot;
  // sorted list of occupied slots, built by insertion as the ring rotates
  logic [SlotW-1:0] srt [MAX_NODES];
  logic [CW-1:0] nsrt;
  logic [CW-1:0] gi;
  logic [31:0] max_gap;
  logic [TimeW-1:0] new_dl;
  // expired entry held back so the final one can carry the marker
  out_item_t hold;

  rec_t ring [MAX_NODES+1];
  rec_t head_new;
  logic shift;

  assign ring[0] = head_new;
  genvar g;
  generate
    for (g = 0; g < MAX_NODES; g++) begin : gen_cell
      nsr_cell u_cell (
        .clk(clk), .rst(rst), .shift(shift), .rec_in(ring[g]), .rec_out(ring[g+1])
      );
    end
  endgenerate
  rec_t head;
  assign head = ring[MAX_NODES];

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign shift = (state == S_IDSCAN) || (state == S_SORT) || (state == S_ROT);

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= 16'd10000;
      silence_lim <= 40'd20000000;
      pad <= 40'd1000000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PERIOD:  period <= cfg_data[SlotW-1:0];
        REG_SILENCE: silence_lim <= cfg_data;
        REG_PAD:     pad <= cfg_data;
        default: ;
      endcase
    end
  end

  // deadline taken from the accepted item time; stable during the rotation
  logic [TimeW:0] dl_sum;
  always_ff @(posedge clk) begin
    if (state == S_IDLE)
      dl_sum <= {1'b0, cmd.now_us} + {9'd0, silence_lim} + {9'd0, pad};
  end
  assign new_dl = dl_sum[TimeW] ? TimeMax : dl_sum[TimeW-1:0];

  logic [TimeW-1:0] silence;
  logic expire, match;
  assign silence = (item.now_us >= head.last_seen) ? item.now_us - head.last_seen : '0;
  assign expire = head.valid && (head.deadline <= item.now_us)
                  && (silence >= {8'd0, silence_lim});
  assign match = head.valid && (head.id == item.node_id);

  logic [SlotW-1:0] per;
  assign per = (period == '0) ? SlotW'(1) : period;

  // gap walk combinational values
  logic [31:0] cur, nxt, gap, mid;
  logic [IW-1:0] gidx, gnxt;
  assign gidx = gi[IW-1:0];
  assign gnxt = (gi + 1'b1 == nsrt) ? '0 : IW'(gi + 1'b1);
  assign cur = {16'd0, srt[gidx]};
  assign nxt = {16'd0, srt[gnxt]};
  assign gap = (gi + 1'b1 == nsrt) ? nxt - cur + {16'd0, per} : nxt - cur;
  assign mid = cur + {1'b0, gap[31:1]};

  // restoring remainder of the chosen midpoint by the period, one bit a cycle
  logic [31:0] mod_num;
  logic [SlotW:0] mod_rem, rem_sh, rem_nx;
  logic [4:0] mod_cnt;
  assign rem_sh = {mod_rem[SlotW-1:0], mod_num[31]};
  assign rem_nx = (rem_sh >= {1'b0, per}) ? rem_sh - {1'b0, per} : rem_sh;

  always_comb begin
    head_new = head;
    if (state == S_ROT) begin
      case (item.command)
        CMD_CREATE: begin
          if (!head.valid && !placed) begin
            head_new.valid = 1'b1;
            head_new.id = item.node_id;
            head_new.slot = new_slot;
            head_new.last_seen = item.now_us;
            head_new.deadline = new_dl;
          end
        end
        CMD_REMOVE: if (match) head_new.valid = 1'b0;
        CMD_KEEPALIVE: begin
          if (match) begin
            head_new.last_seen = item.now_us;
            head_new.deadline = new_dl;
          end
        end
        default: if (expire) head_new.valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      next_id <= 32'd2;
      live <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cnt <= '0;
            found <= 1'b0;
            placed <= 1'b0;
            any <= 1'b0;
            nsrt <= '0;
            gi <= '0;
            max_gap <= '0;
            new_slot <= '0;
            mod_num <= '0;
            mod_rem <= '0;
            mod_cnt <= '0;
            if (cmd.command == CMD_CREATE) begin
              item <= '{cmd.command, next_id, cmd.now_us};
              if (live >= CW'(MAX_NODES)) begin
                done <= 1'b1;
                result <= '{ST_FULL, '0, '0, 5'(live), 1'b1};
              end else begin
                next_id <= next_id + 1'b1;
                state <= S_IDSCAN;
              end
            end else begin
              item <= cmd;
              state <= S_ROT;
            end
          end
        end
        S_IDSCAN: begin
          if (match) found <= 1'b1;
          cnt <= cnt + 1'b1;
          if (cnt == RW'(MAX_NODES - 1)) begin
            cnt <= '0;
            if (found || match) begin
              done <= 1'b1;
              result <= '{ST_FULL, item.node_id, '0, 5'(live), 1'b1};
              state <= S_IDLE;
            end else begin
              state <= S_SORT;
            end
          end
        end
        S_SORT: begin
          if (head.valid) begin
            for (int k = MAX_NODES - 1; k >= 0; k--) begin
              if (CW'(k) < nsrt && srt[k] > head.slot) begin
                if (k + 1 < MAX_NODES) srt[k+1] <= srt[k];
              end
              if (CW'(k) <= nsrt && (k == 0 || srt[(k == 0) ? 0 : k-1] <= head.slot
                  || CW'(k) > nsrt) && (CW'(k) == nsrt || srt[k] > head.slot))
                srt[k] <= head.slot;
            end
            nsrt <= nsrt + 1'b1;
          end
          cnt <= cnt + 1'b1;
          if (cnt == RW'(MAX_NODES - 1)) begin
            cnt <= '0;
            state <= S_GAP;
          end
        end
        S_GAP: begin
          if (nsrt == '0) begin
            state <= S_ROT;
          end else begin
            if (gap > max_gap) begin
              max_gap <= gap;
              mod_num <= mid;
            end
            gi <= gi + 1'b1;
            if (gi + 1'b1 == nsrt) state <= S_MOD;
          end
        end
        S_MOD: begin
          mod_num <= {mod_num[30:0], 1'b0};
          mod_rem <= rem_nx;
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == 5'd31) begin
            new_slot <= rem_nx[SlotW-1:0];
            state <= S_ROT;
          end
        end
        S_ROT: begin
          cnt <= cnt + 1'b1;
          case (item.command)
            CMD_CREATE: if (!head.valid && !placed) placed <= 1'b1;
            CMD_REMOVE, CMD_KEEPALIVE: if (match) found <= 1'b1;
            default: begin
              if (expire) begin
                any <= 1'b1;
                live <= live - 1'b1;
                hold <= '{ST_OK, head.id, '0, 5'(live - 1'b1), 1'b0};
                if (any) begin
                  done <= 1'b1;
                  result <= hold;
                end
              end
            end
          endcase
          if (cnt == RW'(MAX_NODES - 1)) begin
            case (item.command)
              CMD_CREATE: begin
                live <= live + 1'b1;
                done <= 1'b1;
                result <= '{ST_OK, item.node_id, new_slot, 5'(live + 1'b1), 1'b1};
                state <= S_IDLE;
              end
              CMD_REMOVE, CMD_KEEPALIVE: begin
                done <= 1'b1;
                if (found || match) begin
                  if (item.command == CMD_REMOVE) begin
                    live <= live - 1'b1;
                    result <= '{ST_OK, item.node_id, '0, 5'(live - 1'b1), 1'b1};
                  end else begin
                    result <= '{ST_OK, item.node_id, '0, 5'(live), 1'b1};
                  end
                end else begin
                  result <= '{ST_NOT_FOUND, item.node_id, '0, 5'(live), 1'b1};
                end
                state <= S_IDLE;
              end
              default: state <= S_NONE;
            endcase
          end
        end
        S_NONE: begin
          // a check emits its last-result marker in S_NONE, after the rotation
          done <= 1'b1;
          if (any)
            result <= '{hold.status, hold.result_id, hold.result_slot, hold.node_count, 1'b1};
          else
            result <= '{ST_NONE, '0, '0, 5'(live), 1'b1};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sim/registry_checker.sv @@
`timescale 1ns / 1ps
module registry_checker
  import nsr_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    cmd,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data,
  input  logic        done,
  input  out_item_t   result,
  output int          pending,
  output int          mismatches
);
  logic             occ      [MAX_NODES];
  logic [IdW-1:0]   node_ids [MAX_NODES];
  logic [SlotW-1:0] slots    [MAX_NODES];
  logic [TimeW-1:0] seen     [MAX_NODES];
  logic [TimeW-1:0] due      [MAX_NODES];
  logic [IdW-1:0]   id_counter;
  logic [4:0]       live;
  logic [15:0]      period;
  logic [39:0]      silence_limit;
  logic [39:0]      pad;
  out_item_t        expected_results[$];

  function automatic logic [TimeW-1:0] deadline_for(logic [TimeW-1:0] now);
    logic [49:0] sum;
    sum = now + silence_limit + pad;
    return (sum > {2'b00, TimeMax}) ? TimeMax : sum[TimeW-1:0];
  endfunction

  function automatic int lookup(logic [IdW-1:0] id);
    for (int i = 0; i < MAX_NODES; i++)
      if (occ[i] && node_ids[i] == id) return i;
    return -1;
  endfunction

  // largest circular gap between sorted slots, midpoint, first gap wins ties
  function automatic logic [SlotW-1:0] free_slot();
    logic [31:0] s[MAX_NODES];
    logic [31:0] per, gap, best, widest, v;
    int n, j;
    n = 0;
    best = 0;
    widest = 0;
    per = (period == 0) ? 32'd1 : {16'd0, period};
    for (int i = 0; i < MAX_NODES; i++) begin
      if (occ[i]) begin
        v = {16'd0, slots[i]};
        j = n;
        while (j > 0 && s[j-1] > v) begin
          s[j] = s[j-1];
          j--;
        end
        s[j] = v;
        n++;
      end
    end
    if (n == 0) return '0;
    for (int i = 0; i < n; i++) begin
      gap = s[(i + 1) % n] - s[i];
      if (i == n - 1) gap = gap + per;
      if (gap > widest) begin
        widest = gap;
        best = (s[i] + gap / 2) % per;
      end
    end
    return best[SlotW-1:0];
  endfunction

  function automatic out_item_t make_result(logic [1:0] st, logic [IdW-1:0] id,
                                            logic [SlotW-1:0] sl, logic fin);
    out_item_t r;
    r.status = st;
    r.result_id = id;
    r.result_slot = sl;
    r.node_count = live;
    r.last_result = fin;
    return r;
  endfunction

  task automatic enqueue(out_item_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic predict(in_item_t it);
    logic [IdW-1:0]   id;
    logic [SlotW-1:0] sl;
    logic [TimeW-1:0] quiet;
    out_item_t        batch[$];
    out_item_t        r;
    int               idx;
    case (cmd_t'(it.command))
      CMD_CREATE: begin
        if (live >= MAX_NODES) begin
          enqueue(make_result(ST_FULL, '0, '0, 1'b1));
        end else begin
          id = id_counter;
          id_counter = id_counter + 1;
          if (lookup(id) >= 0) begin
            enqueue(make_result(ST_FULL, id, '0, 1'b1));
          end else begin
            sl = free_slot();
            for (int i = 0; i < MAX_NODES; i++) begin
              if (!occ[i]) begin
                occ[i] = 1'b1;
                node_ids[i] = id;
                slots[i] = sl;
                seen[i] = it.now_us;
                due[i] = deadline_for(it.now_us);
                live++;
                break;
              end
            end
            enqueue(make_result(ST_OK, id, sl, 1'b1));
          end
        end
      end
      CMD_REMOVE, CMD_KEEPALIVE: begin
        idx = lookup(it.node_id);
        if (idx < 0) begin
          enqueue(make_result(ST_NOT_FOUND, it.node_id, '0, 1'b1));
        end else begin
          if (cmd_t'(it.command) == CMD_REMOVE) begin
            occ[idx] = 1'b0;
            live--;
          end else begin
            seen[idx] = it.now_us;
            due[idx] = deadline_for(it.now_us);
          end
          enqueue(make_result(ST_OK, it.node_id, '0, 1'b1));
        end
      end
      default: begin
        for (int i = 0; i < MAX_NODES; i++) begin
          if (!occ[i] || due[i] > it.now_us) continue;
          quiet = (it.now_us >= seen[i]) ? it.now_us - seen[i] : '0;
          if (quiet >= silence_limit) begin
            occ[i] = 1'b0;
            live--;
            batch.insert(batch.size(), make_result(ST_OK, node_ids[i], '0, 1'b0));
          end
        end
        if (batch.size() == 0) begin
          enqueue(make_result(ST_NONE, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < batch.size(); i++) begin
            r = batch[i];
            r.last_result = (i == batch.size() - 1);
            enqueue(r);
          end
        end
      end
    endcase
  endtask

  task automatic compare(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: status %0d id %0h slot %0d count %0d last %0b",
                 got.status, got.result_id, got.result_slot, got.node_count,
                 got.last_result);
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status || got.result_id !== want.result_id ||
        got.result_slot !== want.result_slot || got.node_count !== want.node_count ||
        got.last_result !== want.last_result) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp %0d/%0h/%0d/%0d/%0b got %0d/%0h/%0d/%0d/%0b",
                 want.status, want.result_id, want.result_slot, want.node_count,
                 want.last_result, got.status, got.result_id, got.result_slot,
                 got.node_count, got.last_result);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_NODES; i++) occ[i] = 1'b0;
      id_counter = 2;
      live = 0;
      period = 16'd10000;
      silence_limit = 40'd20000000;
      pad = 40'd1000000;
      expected_results.delete();
    end else begin
      // results of the previous command come first
      if (done) compare(result);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PERIOD:  period = cfg_data[15:0];
          REG_SILENCE: silence_limit = cfg_data;
          REG_PAD:     pad = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) predict(cmd);
    end
    pending = expected_results.size();
  end
endmodule

@@ sim/node_slot_registry_unit_test.sv @@
`timescale 1ns / 1ps
module node_slot_registry_unit_test;
  import nsr_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    cmd = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [39:0] cfg_data = '0;
  logic        done;
  out_item_t   result;
  int          pending;
  int          mismatches;
  int          idle_cycles = 0;

  logic [TimeW-1:0] clock_us = '0;
  int               creates_sent = 0;
  bit               dense = 1'b0;

  localparam logic [39:0] Max40 = {40{1'b1}};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  node_slot_registry_unit dut (
    .clk, .rst, .start, .busy, .cmd, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .done, .result
  );

  registry_checker chk (
    .clk, .rst, .start, .busy, .cmd, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .done, .result, .pending, .mismatches
  );

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic pause_random();
    int n;
    if (dense) return;
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 60);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic issue(cmd_t c, logic [IdW-1:0] id, logic [TimeW-1:0] now);
    pause_random();
    while (busy) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    cmd.command = c;
    cmd.node_id = id;
    cmd.now_us = now;
    if (c == CMD_CREATE) creates_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [39:0] val);
    while (!cfg_ready) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(0, 9) < 8)
      return 2 + $urandom_range(0, (creates_sent > 0) ? creates_sent - 1 : 0);
    return $urandom();
  endfunction

  task automatic tick_clock();
    logic [TimeW-1:0] step;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0 && clock_us > 500) begin
      clock_us = clock_us - $urandom_range(1, 500);  // time running backwards
    end else begin
      step = (r == 1) ? TimeW'({$urandom(), $urandom()}) & 48'h00FF_FFFF_FFFF
                      : TimeW'($urandom_range(0, 3000));
      clock_us = (TimeMax - clock_us < step) ? TimeMax : clock_us + step;
    end
  endtask

  task automatic random_phase(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      tick_clock();
      r = $urandom_range(0, 99);
      if (r < 35)      issue(CMD_CREATE, $urandom(), clock_us);
      else if (r < 55) issue(CMD_REMOVE, pick_id(), clock_us);
      else if (r < 75) issue(CMD_KEEPALIVE, pick_id(), clock_us);
      else             issue(CMD_CHECK, $urandom(), clock_us);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: default settings
    issue(CMD_CHECK, '0, 48'd0);
    issue(CMD_CREATE, '0, 48'd0);
    issue(CMD_CREATE, '1, 48'd100);
    issue(CMD_CREATE, '0, 48'd200);
    issue(CMD_KEEPALIVE, 32'd3, 48'd1000);
    issue(CMD_KEEPALIVE, 32'hFFFF_FFFF, 48'd1000);
    issue(CMD_REMOVE, 32'd2, 48'd1100);
    issue(CMD_REMOVE, 32'd2, 48'd1200);
    // fill the table, then one create too many
    for (int i = 0; i < 15; i++) issue(CMD_CREATE, '0, 48'd2000 + i);
    // everything silent long enough: all sixteen expire in one check
    issue(CMD_CHECK, '0, 48'd30000000);
    issue(CMD_CHECK, '0, 48'd30000001);
    clock_us = 48'd30000001;
    settle();

    // deadline saturation near the top of the time range
    write_reg(REG_SILENCE, Max40);
    write_reg(REG_PAD, Max40);
    issue(CMD_CREATE, '0, TimeMax - 48'd5);
    issue(CMD_CHECK, '0, TimeMax);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_PERIOD, 40'd10000);
          write_reg(REG_SILENCE, 40'd2000);
          write_reg(REG_PAD, 40'd500);
        end
        1: begin
          write_reg(REG_PERIOD, 40'd1);
          write_reg(REG_SILENCE, 40'd0);
          write_reg(REG_PAD, 40'd0);
        end
        2: begin
          write_reg(REG_PERIOD, 40'd65535);
          write_reg(REG_SILENCE, 40'd5000);
          write_reg(REG_PAD, 40'd0);
        end
        3: begin
          write_reg(REG_PERIOD, 40'd0);
          write_reg(REG_SILENCE, 40'd1000);
          write_reg(REG_PAD, 40'd1000);
          clock_us = 48'hFFFF_F000_0000;
        end
        4: begin
          write_reg(REG_PERIOD, 40'd7);
          write_reg(REG_SILENCE, 40'h80_0000_0000 | $urandom());
          write_reg(REG_PAD, Max40);
          clock_us = 48'h0000_0100_0000;
        end
        default: begin
          write_reg(REG_PERIOD, {24'd0, 16'($urandom())});
          write_reg(REG_SILENCE, 40'd3000);
          write_reg(REG_PAD, 40'd200);
          clock_us = 48'd1000;
        end
      endcase
      dense = (ph == 2);
      random_phase(68);
      dense = 1'b0;
      settle();
    end

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
